// ===== rtl/pssl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssl_pkg
// Shared types, widths and helpers for the packed sorted set lookup block.
// ----------------------------------------------------------------------------
package pssl_pkg;

  // default sizing, handed to the top level parameters
  localparam int MAX_BLOCKS_DEF = 1024;
  localparam int DATA_WORDS_DEF = 4096;
  localparam int FANOUT_DEF     = 17;

  // fixed field widths
  localparam int CNT_W   = 11;  // block_count register
  localparam int IDX_W   = 12;
  localparam int WORD_W  = 32;
  localparam int OFS_W   = 17;
  localparam int ECNT_W  = 8;
  localparam int EBITS_W = 6;
  localparam int HDR_W   = 8;   // header fields of a block
  localparam int POS_W   = 19;  // bit position into data memory
  localparam int SIDX_W  = 11;  // signed binary search bounds
  localparam int META_W  = OFS_W + ECNT_W + EBITS_W;

  // header layout, in bits from block start
  localparam logic [POS_W-1:0] NMS_OFS = POS_W'(8);
  localparam logic [POS_W-1:0] MS_OFS  = POS_W'(16);

  typedef enum logic [1:0] {
    CMD_SKIP  = 2'd0,
    CMD_META  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_QUERY = 2'd3
  } command_t;

  // which field a bit read fetches
  typedef enum logic [2:0] {
    RK_SB  = 3'd0,  // sub-block element width
    RK_NMS = 3'd1,  // mini skip count
    RK_MS  = 3'd2,  // mini skip probe
    RK_MSV = 3'd3,  // selected mini skip value
    RK_EL  = 3'd4   // sub-block element probe
  } rd_kind_t;

  // controller to datapath
  typedef struct packed {
    logic     wr;         // load beat accepted
    logic     q_init;     // query beat accepted
    logic     node_init;  // open a tree node
    logic     tree_rd;    // skip read addressed by node walk
    logic     tree_cmp;   // compare key to skip pointer
    logic     tree_next;  // step to child node
    logic     blk_load;   // latch block metadata
    logic     rb_pos;     // bit read: position
    logic     rb_quot;    // bit read: word quotient
    logic     rb_idx;     // bit read: word indices
    logic     rb_use;     // bit read: consume field
    logic     mid_calc;   // binary search midpoint
    logic     s1_end;     // mini skip search done
    logic     div_step;   // one divider step
    rd_kind_t kind;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic l_in_range;
    logic node_last;
    logic key_eq;
    logic cur_zero;
    logic rb_hit;
    logic lo_le_hi;
    logic hi_neg;
    logic cnt_lt;
    logic div_done;
  } dp_sts_t;

  // mask of the low w bits; 32 or more gives a full word
  function automatic logic [WORD_W-1:0] width_mask(input logic [HDR_W-1:0] w);
    logic [WORD_W-1:0] m;
    if (w >= HDR_W'(WORD_W)) m = '1;
    else m = (WORD_W'(1) << w) - WORD_W'(1);
    return m;
  endfunction

endpackage

// ===== rtl/pssl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssl_dp
// Datapath: the three stores, tree walk registers, bit field reader,
// search bounds and the quotient divider.
// ----------------------------------------------------------------------------
module pssl_dp
  import pssl_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int FANOUT     = FANOUT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_command,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [WORD_W-1:0]  in_word_value,
  input  logic [OFS_W-1:0]   in_bit_offset,
  input  logic [ECNT_W-1:0]  in_element_count,
  input  logic [EBITS_W-1:0] in_element_bits,
  input  logic [WORD_W-1:0]  in_key,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  output logic               found
);

  localparam int BAW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DAW    = $clog2(DATA_WORDS);
  localparam int LW     = $clog2((MAX_BLOCKS + FANOUT) * FANOUT + 1);
  localparam int PW     = $clog2(FANOUT);
  localparam int WIW    = POS_W - 5;
  localparam int DW_W   = DAW + 1;
  localparam int XW     = WIW + DW_W;
  localparam logic [WIW-1:0]  RECIP = WIW'((1 << WIW) / DATA_WORDS);
  localparam logic [DW_W-1:0] DW_L  = DW_W'(DATA_WORDS);

  // stores
  logic [WORD_W-1:0] skip_mem [MAX_BLOCKS];
  logic [META_W-1:0] blk_mem  [MAX_BLOCKS];
  logic [WORD_W-1:0] data_mem [DATA_WORDS];

  logic [CNT_W-1:0]  block_count_r;
  logic [WORD_W-1:0] skip_q, dlo_q, dhi_q;
  logic [META_W-1:0] blk_q;

  // query registers
  logic [WORD_W-1:0]        key_r, key2_r, subkey_r;
  logic [LW-1:0]            n_r, l_r, i_r, end_r, cur_r;
  logic [PW-1:0]            part_r;
  logic [OFS_W-1:0]         start_r;
  logic [ECNT_W-1:0]        count_r;
  logic [EBITS_W-1:0]       nb_r;
  logic [HDR_W-1:0]         sb_r, nms_r;
  logic signed [SIDX_W-1:0] lo_r, hi_r, mid_r;
  logic [POS_W-1:0]         pos_r, el_r;
  logic [WIW-1:0]           q_r;
  logic [DAW-1:0]           widx_lo_r, widx_hi_r;
  logic [ECNT_W-1:0]        rem_r, quo_r;
  logic [3:0]               dcnt_r;
  logic                     found_r;

  logic [BAW-1:0] skip_ra, cur_a;

  // load beats
  logic wr_skip, wr_meta, wr_data;
  assign wr_skip = cmd.wr && (in_command == CMD_SKIP) && (32'(in_index) < MAX_BLOCKS);
  assign wr_meta = cmd.wr && (in_command == CMD_META) && (32'(in_index) < MAX_BLOCKS);
  assign wr_data = cmd.wr && (in_command == CMD_DATA) && (32'(in_index) < DATA_WORDS);

  assign cur_a   = BAW'(cur_r - LW'(1));
  assign skip_ra = cmd.tree_rd ? BAW'(i_r - LW'(1)) : cur_a;

  // skip pointer store
  always_ff @(posedge clk) begin
    if (wr_skip) skip_mem[BAW'(in_index)] <= in_word_value;
    skip_q <= skip_mem[skip_ra];
  end

  // block metadata store
  always_ff @(posedge clk) begin
    if (wr_meta)
      blk_mem[BAW'(in_index)] <= {in_element_bits, in_element_count, in_bit_offset};
    blk_q <= blk_mem[cur_a];
  end

  // data word store, two read ports
  always_ff @(posedge clk) begin
    if (wr_data) data_mem[DAW'(in_index)] <= in_word_value;
    dlo_q <= data_mem[widx_lo_r];
    dhi_q <= data_mem[widx_hi_r];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
    end else if (cfg_we) begin
      block_count_r <= cfg_wdata;
    end
  end

  // tree walk helpers
  logic [LW:0]   end_a, end_b;
  logic [LW-1:0] n_nxt;
  assign end_a = {1'b0, l_r} + (LW+1)'(FANOUT - 1);
  assign end_b = {1'b0, n_r} + (LW+1)'(1);
  assign n_nxt = (32'(block_count_r) < MAX_BLOCKS) ? LW'(block_count_r) : LW'(MAX_BLOCKS);

  // bit read position
  logic [POS_W-1:0]  pos_base;
  logic [HDR_W-1:0]  pos_idx, pos_w, use_w;
  logic [2*HDR_W-1:0] pos_prod;
  always_comb begin
    pos_base = POS_W'(start_r);
    pos_idx  = '0;
    pos_w    = '0;
    use_w    = HDR_W'(HDR_W);
    unique case (cmd.kind)
      RK_SB: begin
        pos_base = POS_W'(start_r);
      end
      RK_NMS: begin
        pos_base = POS_W'(start_r) + NMS_OFS;
      end
      RK_MS: begin
        pos_base = POS_W'(start_r) + MS_OFS;
        pos_idx  = mid_r[HDR_W-1:0];
        pos_w    = HDR_W'(nb_r);
        use_w    = HDR_W'(nb_r);
      end
      RK_MSV: begin
        pos_base = POS_W'(start_r) + MS_OFS;
        pos_idx  = hi_r[HDR_W-1:0];
        pos_w    = HDR_W'(nb_r);
        use_w    = HDR_W'(nb_r);
      end
      RK_EL: begin
        pos_base = el_r;
        pos_idx  = mid_r[HDR_W-1:0];
        pos_w    = sb_r;
        use_w    = sb_r;
      end
      default: begin
        pos_base = POS_W'(start_r);
      end
    endcase
  end
  assign pos_prod = pos_idx * pos_w;

  // word index modulo store depth: reciprocal then one correction
  logic [2*WIW-1:0] q_prod;
  logic [XW-1:0]    qd, rem_a, rem_b;
  logic [DAW-1:0]   lo_idx;
  assign q_prod = pos_r[POS_W-1:5] * RECIP;
  assign qd     = q_r * DW_L;
  assign rem_a  = XW'(pos_r[POS_W-1:5]) - qd;
  assign rem_b  = (rem_a >= XW'(DW_L)) ? rem_a - XW'(DW_L) : rem_a;
  assign lo_idx = DAW'(rem_b);

  // field extract
  logic [2*WORD_W-1:0] cat;
  logic [WORD_W-1:0]   rb_val, target;
  assign cat    = {dhi_q, dlo_q} >> pos_r[4:0];
  assign rb_val = cat[WORD_W-1:0] & width_mask(use_w);
  assign target = (cmd.kind == RK_EL) ? subkey_r : key2_r;

  // search bound helpers
  logic signed [SIDX_W-1:0]   nms_s, cnt_s, sm1, diff;
  logic signed [2*SIDX_W-1:0] p_lo, p_hi;
  assign nms_s = SIDX_W'(nms_r);
  assign cnt_s = SIDX_W'(count_r);
  assign sm1   = SIDX_W'(quo_r) - SIDX_W'(1);
  assign diff  = hi_r - lo_r;
  assign p_lo  = hi_r * sm1;
  assign p_hi  = (hi_r + SIDX_W'(1)) * sm1;

  // divider trial
  logic [ECNT_W:0] dsh;
  assign dsh = {rem_r, quo_r[ECNT_W-1]};

  // query registers
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      key_r   <= in_key;
      n_r     <= n_nxt;
      l_r     <= LW'(1);
      cur_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.node_init) begin
      i_r    <= l_r;
      end_r  <= LW'((end_a > end_b) ? end_b : end_a);
      part_r <= '0;
    end
    if (cmd.tree_cmp) begin
      if (skip_q == key_r) found_r <= 1'b1;
      if (key_r > skip_q) begin
        cur_r  <= i_r;
        part_r <= PW'(i_r - l_r + LW'(1));
      end
      i_r <= i_r + LW'(1);
    end
    if (cmd.tree_next) begin
      l_r <= l_r * LW'(FANOUT) + LW'(part_r) * LW'(FANOUT - 1);
    end
    if (cmd.blk_load) begin
      key2_r  <= key_r - skip_q;
      start_r <= blk_q[OFS_W-1:0];
      count_r <= blk_q[OFS_W +: ECNT_W];
      nb_r    <= blk_q[OFS_W+ECNT_W +: EBITS_W];
    end
    if (cmd.rb_pos)  pos_r <= pos_base + POS_W'(pos_prod);
    if (cmd.rb_quot) q_r <= q_prod[2*WIW-1:WIW];
    if (cmd.rb_idx) begin
      widx_lo_r <= lo_idx;
      widx_hi_r <= (32'(lo_idx) == DATA_WORDS - 1) ? '0 : lo_idx + DAW'(1);
    end
    if (cmd.mid_calc) mid_r <= lo_r + (diff >>> 1);
    if (cmd.s1_end) begin
      el_r   <= POS_W'(start_r) + MS_OFS + POS_W'(nms_r * nb_r);
      rem_r  <= '0;
      quo_r  <= count_r;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (dsh >= {1'b0, nms_r}) begin
        rem_r <= ECNT_W'(dsh - {1'b0, nms_r});
        quo_r <= {quo_r[ECNT_W-2:0], 1'b1};
      end else begin
        rem_r <= dsh[ECNT_W-1:0];
        quo_r <= {quo_r[ECNT_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 4'd1;
    end
    // consume a fetched field
    if (cmd.rb_use) begin
      unique case (cmd.kind)
        RK_SB: begin
          sb_r <= rb_val[HDR_W-1:0];
        end
        RK_NMS: begin
          nms_r <= rb_val[HDR_W-1:0];
          lo_r  <= '0;
          hi_r  <= SIDX_W'(rb_val[HDR_W-1:0]) - SIDX_W'(1);
        end
        RK_MS, RK_EL: begin
          if (rb_val == target) found_r <= 1'b1;
          else if (rb_val < target) lo_r <= mid_r + SIDX_W'(1);
          else hi_r <= mid_r - SIDX_W'(1);
        end
        RK_MSV: begin
          subkey_r <= key2_r - rb_val;
          lo_r     <= SIDX_W'(p_lo);
          hi_r     <= (hi_r == nms_s - SIDX_W'(1)) ? cnt_s - nms_s - SIDX_W'(1)
                                                  : SIDX_W'(p_hi) - SIDX_W'(1);
        end
        default: begin
          sb_r <= sb_r;
        end
      endcase
    end
  end

  // status
  assign sts.l_in_range = (l_r != '0) && (l_r <= n_r);
  assign sts.node_last  = (i_r + LW'(1)) == end_r;
  assign sts.key_eq     = skip_q == key_r;
  assign sts.cur_zero   = cur_r == '0;
  assign sts.rb_hit     = rb_val == target;
  assign sts.lo_le_hi   = lo_r <= hi_r;
  assign sts.hi_neg     = hi_r[SIDX_W-1];
  assign sts.cnt_lt     = count_r < nms_r;
  assign sts.div_done   = dcnt_r == 4'(ECNT_W);

  assign found = found_r;

endmodule

// ===== rtl/pssl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssl_ctrl
// Controller: sequences tree walk, block header reads, both binary searches
// and the divider; raises the result strobe.
// ----------------------------------------------------------------------------
module pssl_ctrl
  import pssl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_TCHK = 17'h00002,
    ST_TRD  = 17'h00004,
    ST_TCMP = 17'h00008,
    ST_TNXT = 17'h00010,
    ST_TEND = 17'h00020,
    ST_BLK  = 17'h00040,
    ST_RP   = 17'h00080,
    ST_RQ   = 17'h00100,
    ST_RA   = 17'h00200,
    ST_RM   = 17'h00400,
    ST_RU   = 17'h00800,
    ST_S1   = 17'h01000,
    ST_S1E  = 17'h02000,
    ST_DIV  = 17'h04000,
    ST_S2   = 17'h08000,
    ST_REP  = 17'h10000
  } state_t;

  state_t   state_r, state_nxt;
  rd_kind_t kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= RK_SB;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr = start;
        if (start && (in_command == CMD_QUERY)) begin
          cmd.q_init = 1'b1;
          state_nxt  = ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (sts.l_in_range) begin
          cmd.node_init = 1'b1;
          state_nxt     = ST_TRD;
        end else begin
          state_nxt = ST_TEND;
        end
      end
      ST_TRD: begin
        cmd.tree_rd = 1'b1;
        state_nxt   = ST_TCMP;
      end
      ST_TCMP: begin
        cmd.tree_cmp = 1'b1;
        if (sts.key_eq) state_nxt = ST_REP;
        else if (sts.node_last) state_nxt = ST_TNXT;
        else state_nxt = ST_TRD;
      end
      ST_TNXT: begin
        cmd.tree_next = 1'b1;
        state_nxt     = ST_TCHK;
      end
      ST_TEND: begin
        // skip and metadata reads of the chosen block are in flight
        state_nxt = sts.cur_zero ? ST_REP : ST_BLK;
      end
      ST_BLK: begin
        cmd.blk_load = 1'b1;
        kind_nxt     = RK_SB;
        state_nxt    = ST_RP;
      end
      // bit field read: position, quotient, index, memory, use
      ST_RP: begin
        cmd.rb_pos = 1'b1;
        state_nxt  = ST_RQ;
      end
      ST_RQ: begin
        cmd.rb_quot = 1'b1;
        state_nxt   = ST_RA;
      end
      ST_RA: begin
        cmd.rb_idx = 1'b1;
        state_nxt  = ST_RM;
      end
      ST_RM: begin
        state_nxt = ST_RU;
      end
      ST_RU: begin
        cmd.rb_use = 1'b1;
        unique case (kind_r)
          RK_SB: begin
            kind_nxt  = RK_NMS;
            state_nxt = ST_RP;
          end
          RK_NMS: state_nxt = ST_S1;
          RK_MS:  state_nxt = sts.rb_hit ? ST_REP : ST_S1;
          RK_MSV: state_nxt = ST_S2;
          RK_EL:  state_nxt = sts.rb_hit ? ST_REP : ST_S2;
          default: state_nxt = ST_REP;
        endcase
      end
      ST_S1: begin
        if (sts.lo_le_hi) begin
          cmd.mid_calc = 1'b1;
          kind_nxt     = RK_MS;
          state_nxt    = ST_RP;
        end else begin
          state_nxt = ST_S1E;
        end
      end
      ST_S1E: begin
        if (sts.hi_neg || sts.cnt_lt) begin
          state_nxt = ST_REP;
        end else begin
          cmd.s1_end = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          kind_nxt  = RK_MSV;
          state_nxt = ST_RP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_S2: begin
        if (sts.lo_le_hi) begin
          cmd.mid_calc = 1'b1;
          kind_nxt     = RK_EL;
          state_nxt    = ST_RP;
        end else begin
          state_nxt = ST_REP;
        end
      end
      ST_REP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = state_r == ST_REP;

endmodule

// ===== rtl/packed_sorted_set_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_sorted_set_lookup
// Membership lookup on a bit-packed sorted integer set.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken when start is high and busy is low. Commands
//   0..2 load the skip pointer table, block metadata table or data words;
//   they complete in the accepting cycle and busy stays low.
//   A query (command 3) raises busy until its result beat: out_valid is high
//   for exactly one cycle with out_found, then busy drops the next cycle.
//   The receiver cannot stall; the result must be taken in that cycle.
//   cfg_we writes block_count (cfg_wdata); the user must do this only while
//   idle, as the block itself does not enforce it.
// A query runs: per tree level, a read of each skip pointer visited; the
//   block load; packed field reads (two header reads, each mini skip probe,
//   the selected mini skip, each sub-block probe) with the search steps;
//   the quotient divider; the result beat. The single-port skip table walk
//   and the field read (position, word index modulo, memory) set the query
//   latency.
// Reset (rst_n low, synchronous) returns to idle and clears block_count;
// store contents are kept and must be written before use.
// ----------------------------------------------------------------------------
module packed_sorted_set_lookup
  import pssl_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int FANOUT     = FANOUT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [WORD_W-1:0]  in_word_value,
  input  logic [OFS_W-1:0]   in_bit_offset,
  input  logic [ECNT_W-1:0]  in_element_count,
  input  logic [EBITS_W-1:0] in_element_bits,
  input  logic [WORD_W-1:0]  in_key,
  output logic               out_valid,
  output logic               out_found,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  pssl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // stores and arithmetic
  pssl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .DATA_WORDS (DATA_WORDS),
    .FANOUT     (FANOUT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_index         (in_index),
    .in_word_value    (in_word_value),
    .in_bit_offset    (in_bit_offset),
    .in_element_count (in_element_count),
    .in_element_bits  (in_element_bits),
    .in_key           (in_key),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .found            (out_found)
  );

endmodule

// ===== rtl/pssl_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssl_chk
// Port-level checks of the query/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module pssl_chk
  import pssl_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input logic       out_valid
);

  // a query beat occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_QUERY) |=> busy)
    else $error("query beat did not raise busy");

  // load beats complete at once
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command != CMD_QUERY) |=> !busy)
    else $error("load beat raised busy");

  // result beat only during a query
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // result beat ends the query
  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("query did not end after its result beat");

endmodule

bind packed_sorted_set_lookup pssl_chk u_pssl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);
